>>> hw/rtl/sbfd_pkg.sv
`timescale 1ns / 1ps
package sbfd_pkg;

  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned PART_W          = 7;
  localparam int unsigned NUM_WORDS       = 7;
  localparam int unsigned DATA_WORDS      = 5;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned SUM_A_W         = 12;  // max 2550
  localparam int unsigned SUM_B_W         = 14;  // max 14025

  localparam logic [SLOT_W-1:0] SLOT_TOP_HIGH   = 6'd5;
  localparam logic [SLOT_W-1:0] SLOT_TOP_LOW    = 6'd7;
  localparam logic [SLOT_W-1:0] SLOT_HIGH_FIRST = 6'd9;
  localparam logic [SLOT_W-1:0] SLOT_HIGH_LAST  = 6'd21;
  localparam logic [SLOT_W-1:0] SLOT_LOW_FIRST  = 6'd23;
  localparam logic [SLOT_W-1:0] SLOT_LAST       = 6'd35;

  typedef logic [15:0] data_word_t;

  typedef struct packed {
    logic [5:0] slot;
    logic [7:0] rx_byte;
  } sbfd_in_t;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
    logic        checksum_ok;
  } sbfd_out_t;

endpackage

>>> hw/rtl/sbfd_stream_if.sv
`timescale 1ns / 1ps
interface sbfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/seven_bit_frame_checksum_deframer_top.sv
`timescale 1ns / 1ps
// channel   dir  payload                               handshake
// in_ch     in   slot[5:0], rx_byte[7:0]               valid/ready
// out_ch    out  word0..word4[15:0], checksum_ok       valid/ready
//
// One word accepted per cycle while in_ch.ready is high; non-data slots vanish,
// other data slots but 35 update state and vanish. A slot-35 word yields a
// result via the input reg, word-rebuild, sums and compare/output regs.
// Stages hold their data under backpressure; in_ch.ready drops only when a
// slot-35 word sits in the input register and the stage behind it is full.
// Synchronous active-low reset clears valids and the stored frame bits.
module seven_bit_frame_checksum_deframer_top
  import sbfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sbfd_stream_if.sink   in_ch,
  sbfd_stream_if.source out_ch
);

  // ---------------- stage A: input register ----------------
  logic              a_v_r;
  logic [SLOT_W-1:0] a_slot_r;
  logic [PART_W-1:0] a_part_r;
  logic              a_adv;

  // ---------------- frame state ----------------
  logic [PART_W-1:0] htop_r, ltop_r;
  logic [PART_W-1:0] hi_r [NUM_WORDS];
  logic [PART_W-1:0] lo_r [NUM_WORDS];

  // ---------------- stage B: rebuilt words ----------------
  logic       b_v_r;
  data_word_t b_words_r [NUM_WORDS];

  // ---------------- stage C: sums ----------------
  logic               c_v_r;
  data_word_t         c_words_r [DATA_WORDS];
  data_word_t         c_w5_r, c_w6_r;
  logic [SUM_A_W-1:0] c_sum_a_r;
  logic [SUM_B_W-1:0] c_sum_b_r;

  // ---------------- stage D: output register ----------------
  logic      d_v_r;
  sbfd_out_t d_data_r;

  logic d_rdy, c_rdy, b_rdy;

  assign d_rdy = !d_v_r || out_ch.ready;
  assign c_rdy = !c_v_r || d_rdy;
  assign b_rdy = !b_v_r || c_rdy;
  assign a_adv = a_v_r && ((a_slot_r != SLOT_LAST) || b_rdy);
  assign in_ch.ready = !a_v_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_slot_r <= in_ch.data.slot;
      a_part_r <= in_ch.data.rx_byte[PART_W-1:0];
    end
  end

  // slot decode
  logic              is_hi, is_lo;
  logic [SLOT_W-1:0] hi_off, lo_off;
  logic [IDX_W-1:0]  hi_idx, lo_idx;

  assign hi_off = a_slot_r - SLOT_HIGH_FIRST;
  assign lo_off = a_slot_r - SLOT_LOW_FIRST;
  assign hi_idx = hi_off[IDX_W:1];
  assign lo_idx = lo_off[IDX_W:1];
  assign is_hi  = a_slot_r[0] && (a_slot_r >= SLOT_HIGH_FIRST) && (a_slot_r <= SLOT_HIGH_LAST);
  assign is_lo  = a_slot_r[0] && (a_slot_r >= SLOT_LOW_FIRST) && (a_slot_r <= SLOT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      htop_r <= '0;
      ltop_r <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        hi_r[i] <= '0;
        lo_r[i] <= '0;
      end
    end else if (a_adv) begin
      if (a_slot_r == SLOT_TOP_HIGH) htop_r <= a_part_r;
      if (a_slot_r == SLOT_TOP_LOW)  ltop_r <= a_part_r;
      for (int i = 0; i < NUM_WORDS; i++) begin
        if (is_hi && hi_idx == IDX_W'(i)) hi_r[i] <= a_part_r;
        if (is_lo && lo_idx == IDX_W'(i)) lo_r[i] <= a_part_r;
      end
    end
  end

  // rebuild; slot 35 carries the low part of the last word itself
  data_word_t words_nxt [NUM_WORDS];

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_nxt[i] = {htop_r[i], hi_r[i], ltop_r[i],
                      (i == NUM_WORDS - 1) ? a_part_r : lo_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r && (a_slot_r == SLOT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r && (a_slot_r == SLOT_LAST)) begin
      b_words_r <= words_nxt;
    end
  end

  // plain and weighted sums: high bytes weigh 10..6, low bytes 5..1
  logic [SUM_A_W-1:0] sum_a_nxt;
  logic [SUM_B_W-1:0] sum_b_nxt;

  always_comb begin
    sum_a_nxt = '0;
    sum_b_nxt = '0;
    for (int i = 0; i < DATA_WORDS; i++) begin
      sum_a_nxt = sum_a_nxt + SUM_A_W'(b_words_r[i][15:8]) + SUM_A_W'(b_words_r[i][7:0]);
      sum_b_nxt = sum_b_nxt
                + SUM_B_W'(b_words_r[i][15:8]) * SUM_B_W'(2 * DATA_WORDS - i)
                + SUM_B_W'(b_words_r[i][7:0]) * SUM_B_W'(DATA_WORDS - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_v_r) begin
      for (int i = 0; i < DATA_WORDS; i++) c_words_r[i] <= b_words_r[i];
      c_w5_r    <= b_words_r[DATA_WORDS];
      c_w6_r    <= b_words_r[DATA_WORDS + 1];
      c_sum_a_r <= sum_a_nxt;
      c_sum_b_r <= sum_b_nxt;
    end
  end

  sbfd_out_t d_data_nxt;

  always_comb begin
    d_data_nxt.word0       = c_words_r[0];
    d_data_nxt.word1       = c_words_r[1];
    d_data_nxt.word2       = c_words_r[2];
    d_data_nxt.word3       = c_words_r[3];
    d_data_nxt.word4       = c_words_r[4];
    d_data_nxt.checksum_ok = (16'(c_sum_a_r) == c_w5_r) && (16'(c_sum_b_r) == c_w6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_rdy) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && c_v_r) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign out_ch.valid = d_v_r;
  assign out_ch.data  = d_data_r;

`ifndef NO_ASSERTIONS
  a_last_reaches_b: assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && (a_slot_r == SLOT_LAST) |=> b_v_r)
    else $error("slot-35 word did not reach rebuild stage");

  a_ready_low_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> a_v_r && (a_slot_r == SLOT_LAST) && b_v_r)
    else $error("input stalled without a blocked frame end");

  a_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !d_rdy |=> c_v_r && $stable(c_sum_a_r) && $stable(c_sum_b_r))
    else $error("sum stage changed while blocked");
`endif

endmodule

>>> sim/seven_bit_frame_checksum_deframer_top_tb.sv
`timescale 1ns / 1ps
module seven_bit_frame_checksum_deframer_top_tb;
  import sbfd_pkg::*;

  localparam int FRAME_SLOTS = 40;

  typedef struct packed {
    logic [5:0] slot;
    logic [7:0] rx_byte;
    bit         fixed;
    sbfd_out_t  fixed_out;
  } dir_row_t;

  localparam sbfd_out_t ZEROS_OK  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1};
  localparam sbfd_out_t ZEROS_BAD = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
  localparam sbfd_out_t ONES_BAD  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};

  logic clk;
  logic rst_n;

  sbfd_stream_if #(.T(sbfd_in_t))  in_ch ();
  sbfd_stream_if #(.T(sbfd_out_t)) out_ch ();

  seven_bit_frame_checksum_deframer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // non-data slots first: all-ones bytes there must leave the frame untouched
  dir_row_t directed_tbl [25] = '{
    '{6'd0,  8'hFF, 1'b0, '0},
    '{6'd1,  8'hFF, 1'b0, '0},
    '{6'd3,  8'hFF, 1'b0, '0},
    '{6'd6,  8'hFF, 1'b0, '0},
    '{6'd36, 8'hFF, 1'b0, '0},
    '{6'd37, 8'hFF, 1'b0, '0},
    '{6'd39, 8'hFF, 1'b0, '0},
    '{6'd35, 8'h00, 1'b1, ZEROS_OK},
    '{6'd35, 8'hFF, 1'b1, ZEROS_BAD},
    '{6'd5,  8'hFF, 1'b0, '0},
    '{6'd7,  8'hFF, 1'b0, '0},
    '{6'd9,  8'hFF, 1'b0, '0},
    '{6'd11, 8'hFF, 1'b0, '0},
    '{6'd13, 8'hFF, 1'b0, '0},
    '{6'd15, 8'hFF, 1'b0, '0},
    '{6'd17, 8'hFF, 1'b0, '0},
    '{6'd19, 8'hFF, 1'b0, '0},
    '{6'd21, 8'hFF, 1'b0, '0},
    '{6'd23, 8'hFF, 1'b0, '0},
    '{6'd25, 8'hFF, 1'b0, '0},
    '{6'd27, 8'hFF, 1'b0, '0},
    '{6'd29, 8'hFF, 1'b0, '0},
    '{6'd31, 8'hFF, 1'b0, '0},
    '{6'd33, 8'hFF, 1'b0, '0},
    '{6'd35, 8'hFF, 1'b1, ONES_BAD}
  };

  int idle_plan  [4] = '{0, 57, 0, 25};
  int stall_plan [4] = '{0, 0, 57, 25};
  string field_name [6] = '{"word0", "word1", "word2", "word3", "word4", "checksum_ok"};

  int send_idle_pct;
  int recv_stall_pct;
  int errors = 0;

  // shadow of the frame being assembled
  logic [6:0] high_tops = '0;
  logic [6:0] low_tops  = '0;
  data_word_t frame_words [7] = '{default: '0};

  sbfd_out_t frames_due [$];
  sbfd_in_t  frame_q [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit deframe(input sbfd_in_t w, output sbfd_out_t r);
    logic [6:0] part;
    int idx;
    int plain;
    int weighted;
    part = w.rx_byte[6:0];
    r = '0;
    if (w.slot >= FRAME_SLOTS || !w.slot[0] || w.slot < SLOT_TOP_HIGH || w.slot > SLOT_LAST)
      return 1'b0;
    if (w.slot == SLOT_TOP_HIGH) begin
      high_tops = part;
      return 1'b0;
    end
    if (w.slot == SLOT_TOP_LOW) begin
      low_tops = part;
      return 1'b0;
    end
    if (w.slot < SLOT_LOW_FIRST) begin
      idx = (w.slot - SLOT_HIGH_FIRST) >> 1;
      frame_words[idx][14:8] = part;
      return 1'b0;
    end
    idx = (w.slot - SLOT_LOW_FIRST) >> 1;
    frame_words[idx][6:0] = part;
    if (w.slot != SLOT_LAST)
      return 1'b0;

    for (int i = 0; i < NUM_WORDS; i++) begin
      frame_words[i][15] = high_tops[i];
      frame_words[i][7]  = low_tops[i];
    end
    // weights 10..6 on the high bytes, 5..1 on the low bytes
    plain = 0;
    weighted = 0;
    for (int i = 0; i < DATA_WORDS; i++) begin
      plain += frame_words[i][15:8] + frame_words[i][7:0];
      weighted += frame_words[i][15:8] * (10 - i) + frame_words[i][7:0] * (5 - i);
    end
    r = '{frame_words[0], frame_words[1], frame_words[2], frame_words[3], frame_words[4],
          (16'(plain) == frame_words[5]) && (16'(weighted) == frame_words[6])};
    return 1'b1;
  endfunction

  task automatic send_word(input sbfd_in_t w, input bit fixed, input sbfd_out_t fixed_out);
    sbfd_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (deframe(w, predicted))
      frames_due.push_back(fixed ? fixed_out : predicted);
  endtask

  task automatic check_result(input sbfd_out_t got);
    sbfd_out_t want;
    logic [15:0] want_f [6];
    logic [15:0] got_f [6];
    if (frames_due.size() == 0) begin
      $error("unexpected result: %h", got);
      errors++;
      return;
    end
    want = frames_due.pop_front();
    want_f = '{want.word0, want.word1, want.word2, want.word3, want.word4,
               {15'd0, want.checksum_ok}};
    got_f = '{got.word0, got.word1, got.word2, got.word3, got.word4,
              {15'd0, got.checksum_ok}};
    for (int i = 0; i < 6; i++) begin
      if (got_f[i] !== want_f[i]) begin
        $error("%s: expected %h, got %h", field_name[i], want_f[i], got_f[i]);
        errors++;
      end
    end
  endtask

  function automatic data_word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sbfd_in_t noise_word();
    logic [5:0] s;
    do s = 6'($urandom_range(0, 39)); while (s[0] && s >= SLOT_TOP_HIGH && s <= SLOT_LAST);
    return '{s, 8'($urandom)};
  endfunction

  // serialize seven words into slot order; bit 7 of each byte is don't-care
  function automatic void queue_frame(input data_word_t wds [7]);
    logic [6:0] tops_h;
    logic [6:0] tops_l;
    for (int i = 0; i < NUM_WORDS; i++) begin
      tops_h[i] = wds[i][15];
      tops_l[i] = wds[i][7];
    end
    frame_q.delete();
    frame_q.push_back('{SLOT_TOP_HIGH, {1'($urandom_range(0, 1)), tops_h}});
    frame_q.push_back('{SLOT_TOP_LOW, {1'($urandom_range(0, 1)), tops_l}});
    for (int i = 0; i < NUM_WORDS; i++)
      frame_q.push_back('{6'(SLOT_HIGH_FIRST + 2 * i), {1'($urandom_range(0, 1)), wds[i][14:8]}});
    for (int i = 0; i < NUM_WORDS; i++)
      frame_q.push_back('{6'(SLOT_LOW_FIRST + 2 * i), {1'($urandom_range(0, 1)), wds[i][6:0]}});
  endfunction

  task automatic run_frames(input int quota);
    data_word_t wds [7];
    int sent;
    int kind;
    int plain;
    int weighted;
    sent = 0;
    while (sent < quota) begin
      plain = 0;
      weighted = 0;
      for (int i = 0; i < DATA_WORDS; i++) begin
        wds[i] = pick_word();
        plain += wds[i][15:8] + wds[i][7:0];
        weighted += wds[i][15:8] * (10 - i) + wds[i][7:0] * (5 - i);
      end
      wds[5] = 16'(plain);
      wds[6] = 16'(weighted);
      queue_frame(wds);
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        if ($urandom_range(0, 2) == 0)
          for (int k = frame_q.size(); k >= 0; k--)
            if ($urandom_range(0, 5) == 0)
              frame_q.insert(k, noise_word());
      end else if (kind < 16) begin
        frame_q[$urandom_range(0, 15)].rx_byte ^= 8'(1 << $urandom_range(0, 6));
      end else if (kind < 18) begin
        // dropped slots keep whatever they held from earlier frames
        repeat ($urandom_range(1, 3)) frame_q.delete($urandom_range(0, frame_q.size() - 1));
      end else begin
        frame_q.delete();
        repeat (16) frame_q.push_back('{6'($urandom_range(0, 39)), 8'($urandom)});
      end
      foreach (frame_q[k])
        send_word(frame_q[k], 1'b0, '0);
      sent += frame_q.size();
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        check_result(out_ch.data);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tbl[k])
      send_word('{directed_tbl[k].slot, directed_tbl[k].rx_byte}, directed_tbl[k].fixed,
                directed_tbl[k].fixed_out);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      run_frames(425);
      if (p == 1) begin
        // let the pipeline drain completely before going on
        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
